[src/drfs_pkg.sv]
// shared types, codes and constants of the delimited record field splitter
// no dependencies; imported by the result interface and by every module of the block
package drfs_pkg;

    typedef enum logic [1:0]
    {
        KIND_CHAR   = 2'd0,
        KIND_RECORD = 2'd1,
        KIND_LIST   = 2'd2
    } kind_t;

    localparam logic [7:0] REC_SEP     = 8'h1e;
    localparam logic [7:0] FLD_SEP     = 8'h1f;
    localparam logic [7:0] SCORE_ONE   = 8'h31;
    localparam logic [2:0] SCORE_FIELD = 3'd6;
    localparam logic [2:0] FIELD_MAX   = 3'd7;
    localparam logic [4:0] LENGTH_MAX  = 5'd31;
    localparam int         FIFO_DEPTH  = 4;

    typedef struct packed
    {
        kind_t       kind;
        logic [3:0]  record_index;
        logic [2:0]  field_index;
        logic [4:0]  char_position;
        logic [7:0]  out_byte;
        logic        with_scores;
        logic [3:0]  record_count;
        logic        last;
    } result_t;

    // results made by one accepted byte, in order
    typedef struct packed
    {
        logic [1:0]  count;
        result_t     first;
        result_t     second;
    } push_t;

    function automatic logic [4:0] field_limit(input logic [2:0] field);
        logic [4:0] limit;
        begin
            case (field)
                3'd0:    limit = 5'd3;
                3'd1:    limit = 5'd5;
                3'd2:    limit = 5'd4;
                3'd3:    limit = 5'd5;
                3'd4:    limit = 5'd4;
                3'd5:    limit = 5'd23;
                default: limit = 5'd0;
            endcase
            return limit;
        end
    endfunction

endpackage

[src/drfs_in_if.sv]
// input channel of the splitter: one list byte or the end marker per transaction
// no dependencies
interface drfs_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  in_byte;
    logic        string_end;

    modport source (output valid, output in_byte, output string_end, input ready);
    modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

[src/drfs_out_if.sv]
// result channel of the splitter: one character, record or list report per transaction
// depends on drfs_pkg for the kind codes
interface drfs_out_if
    import drfs_pkg::*;
;
    logic        valid;
    logic        ready;
    kind_t       kind;
    logic [3:0]  record_index;
    logic [2:0]  field_index;
    logic [4:0]  char_position;
    logic [7:0]  out_byte;
    logic        with_scores;
    logic [3:0]  record_count;
    logic        last;

    modport source (output valid, output kind, output record_index, output field_index,
                    output char_position, output out_byte, output with_scores,
                    output record_count, output last, input ready);
    modport sink   (input valid, input kind, input record_index, input field_index,
                    input char_position, input out_byte, input with_scores,
                    input record_count, input last, output ready);
endinterface

[src/drfs_parser.sv]
// parser state and per-byte decode: turns one accepted byte into up to two results
// depends on drfs_pkg
module drfs_parser
    import drfs_pkg::*;
#(
    parameter int MAX_RECORDS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  in_byte,
    input  logic        string_end,
    output push_t       push
);

    localparam int RW = $clog2(MAX_RECORDS + 1);
    localparam int CW = (RW > 4) ? RW : 4;
    localparam logic [RW-1:0] REC_LIMIT = RW'(MAX_RECORDS);

    logic [RW-1:0] record_counter_reg, record_counter_next;
    logic [2:0]    field_counter_reg, field_counter_next;
    logic [4:0]    field_length_reg, field_length_next;
    logic          score_flag_reg, score_flag_next;
    logic          record_started_reg, record_started_next;
    logic          list_full_reg, list_full_next;

    logic [RW-1:0] counter_inc;
    logic [CW-1:0] counter_ext;
    logic [CW-1:0] inc_ext;
    result_t       rec_res;
    result_t       list_res;
    result_t       char_res;

    assign counter_inc = record_counter_reg + 1'b1;
    assign counter_ext = CW'(record_counter_reg);
    assign inc_ext     = CW'(counter_inc);

    always_comb
    begin
        rec_res              = '0;
        rec_res.kind         = KIND_RECORD;
        rec_res.record_index = counter_ext[3:0];
        rec_res.with_scores  = score_flag_reg;
        rec_res.last         = 1'b1;

        list_res             = '0;
        list_res.kind        = KIND_LIST;
        list_res.last        = 1'b1;

        char_res               = '0;
        char_res.kind          = KIND_CHAR;
        char_res.record_index  = counter_ext[3:0];
        char_res.field_index   = field_counter_reg;
        char_res.char_position = field_length_reg;
        char_res.out_byte      = in_byte;
        char_res.last          = 1'b1;
    end

    always_comb
    begin
        record_counter_next = record_counter_reg;
        field_counter_next  = field_counter_reg;
        field_length_next   = field_length_reg;
        score_flag_next     = score_flag_reg;
        record_started_next = record_started_reg;
        list_full_next      = list_full_reg;
        push                = '0;

        if (accept)
        begin
            if (string_end)
            begin
                if (!list_full_reg && record_started_reg)
                begin
                    push.count               = 2'd2;
                    push.first               = rec_res;
                    push.first.last          = 1'b0;
                    push.second              = list_res;
                    push.second.record_count = inc_ext[3:0];
                end
                else
                begin
                    push.count              = 2'd1;
                    push.first              = list_res;
                    push.first.record_count = counter_ext[3:0];
                end
                record_counter_next = '0;
                list_full_next      = 1'b0;
                field_counter_next  = '0;
                field_length_next   = '0;
                score_flag_next     = 1'b0;
                record_started_next = 1'b0;
            end
            else if (list_full_reg)
            begin
                // bytes dropped until the end marker
            end
            else if (in_byte == REC_SEP)
            begin
                push.count          = 2'd1;
                push.first          = rec_res;
                record_counter_next = counter_inc;
                list_full_next      = (counter_inc >= REC_LIMIT);
                field_counter_next  = '0;
                field_length_next   = '0;
                score_flag_next     = 1'b0;
                record_started_next = 1'b0;
            end
            else if (in_byte == FLD_SEP)
            begin
                record_started_next = 1'b1;
                if (field_counter_reg != FIELD_MAX)
                begin
                    field_counter_next = field_counter_reg + 3'd1;
                end
                field_length_next = '0;
            end
            else
            begin
                record_started_next = 1'b1;
                if (field_counter_reg < SCORE_FIELD)
                begin
                    if (field_length_reg < field_limit(field_counter_reg))
                    begin
                        push.count = 2'd1;
                        push.first = char_res;
                    end
                end
                else if (field_counter_reg == SCORE_FIELD && field_length_reg == 5'd0)
                begin
                    score_flag_next = (in_byte == SCORE_ONE);
                end
                if (field_length_reg != LENGTH_MAX)
                begin
                    field_length_next = field_length_reg + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_counter_reg <= '0;
            field_counter_reg  <= '0;
            field_length_reg   <= '0;
            score_flag_reg     <= 1'b0;
            record_started_reg <= 1'b0;
            list_full_reg      <= 1'b0;
        end
        else
        begin
            record_counter_reg <= record_counter_next;
            field_counter_reg  <= field_counter_next;
            field_length_reg   <= field_length_next;
            score_flag_reg     <= score_flag_next;
            record_started_reg <= record_started_next;
            list_full_reg      <= list_full_next;
        end
    end

    a_full_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        list_full_reg |-> record_counter_reg == REC_LIMIT)
        else $error("list full without the record limit reached");

    a_idle_record_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !record_started_reg |-> (field_counter_reg == 3'd0 && field_length_reg == 5'd0
                                 && !score_flag_reg))
        else $error("record not started but field state left over");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> (push.first.kind == KIND_RECORD && !push.first.last
                                && push.second.kind == KIND_LIST && push.second.last))
        else $error("two-result push not record then list");

    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> accept)
        else $error("results pushed without an accepted byte");

endmodule

[src/drfs_out_fifo.sv]
// small result queue: takes up to two results a cycle, hands out one per transaction
// depends on drfs_pkg and drfs_out_if
module drfs_out_fifo
    import drfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  push_t       push,
    output logic        in_ready,
    drfs_out_if.source  out_ch
);

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int NW = $clog2(FIFO_DEPTH + 1);

    result_t        entry_reg [FIFO_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]  count_reg, count_next;
    logic           pop;
    result_t        head;

    assign pop      = out_ch.valid && out_ch.ready;
    assign in_ready = (count_reg <= NW'(FIFO_DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + PW'(push.count);
    assign rd_ptr_next = rd_ptr_reg + PW'(pop);
    assign count_next  = count_reg + NW'(push.count) - NW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[PW'(wr_ptr_reg + 1'b1)] <= push.second;
        end
    end

    assign head                 = entry_reg[rd_ptr_reg];
    assign out_ch.valid         = (count_reg != '0);
    assign out_ch.kind          = head.kind;
    assign out_ch.record_index  = head.record_index;
    assign out_ch.field_index   = head.field_index;
    assign out_ch.char_position = head.char_position;
    assign out_ch.out_byte      = head.out_byte;
    assign out_ch.with_scores   = head.with_scores;
    assign out_ch.record_count  = head.record_count;
    assign out_ch.last          = head.last;

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg > NW'(FIFO_DEPTH - 2) |-> push.count == 2'd0)
        else $error("push into queue without room for two");

endmodule

[src/delimited_record_field_splitter.sv]
// delimited record field splitter: takes list bytes and registers their results in a result queue
// throughput: one byte per cycle while the input is ready; an end marker inside a record gives two
// results, queued together and delivered in order from a four-entry result queue that keeps the input ready
// whenever the queue holds two or fewer results
// asynchronous active-low reset clears the parser state and empties the result queue
// depends on drfs_pkg, drfs_in_if, drfs_out_if, drfs_parser, drfs_out_fifo
module delimited_record_field_splitter
    import drfs_pkg::*;
#(
    parameter int MAX_RECORDS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    drfs_in_if.sink     in_ch,
    drfs_out_if.source  out_ch
);

    logic   accept;
    logic   fifo_ready;
    push_t  push;

    assign in_ch.ready = fifo_ready;
    assign accept      = in_ch.valid && fifo_ready;

    drfs_parser #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (in_ch.in_byte),
        .string_end (in_ch.string_end),
        .push       (push)
    );

    drfs_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .in_ready (fifo_ready),
        .out_ch   (out_ch)
    );

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// testbench for delimited_record_field_splitter: directed and random byte lists with
// random idling on both channels, every result checked in order against a predicted queue
// depends on drfs_pkg, drfs_in_if, drfs_out_if and the splitter rtl
module tb;
    import drfs_pkg::*;

    localparam int MAX_REC         = 12;
    localparam int ITEMS_PER_PHASE = 434;

    class splitter_scoreboard;
        result_t    expected_q[$];
        int         mismatches;
        int         results_checked;
        int         lists_done;
        int         records_done;
        int         chars_done;
        int         full_lists;

        // parser state as the block should hold it
        logic [3:0] rec_num;
        logic [2:0] fld_num;
        logic [4:0] fld_len;
        logic       score;
        logic       started;
        logic       full;

        function new();
            rec_num = 4'd0;
            full    = 1'b0;
            start_record();
        endfunction

        function void start_record();
            fld_num = 3'd0;
            fld_len = 5'd0;
            score   = 1'b0;
            started = 1'b0;
        endfunction

        function int cap_of(input logic [2:0] fld);
            case (fld)
                3'd0:    return 3;
                3'd1:    return 5;
                3'd2:    return 4;
                3'd3:    return 5;
                3'd4:    return 4;
                default: return 23;
            endcase
        endfunction

        function void push_result(input kind_t k, input logic [3:0] rec, input logic [2:0] fld,
                                  input logic [4:0] pos, input logic [7:0] b,
                                  input logic flag, input logic [3:0] cnt);
            result_t r;
            r.kind          = k;
            r.record_index  = rec;
            r.field_index   = fld;
            r.char_position = pos;
            r.out_byte      = b;
            r.with_scores   = flag;
            r.record_count  = cnt;
            r.last          = 1'b0;
            expected_q.push_back(r);
        endfunction

        function void note_byte(input logic [7:0] b, input logic at_end);
            int      queued;
            result_t tail;
            queued = expected_q.size();
            if (at_end)
            begin
                if (!full && started)
                begin
                    push_result(KIND_RECORD, rec_num, 3'd0, 5'd0, 8'd0, score, 4'd0);
                    rec_num++;
                end
                push_result(KIND_LIST, 4'd0, 3'd0, 5'd0, 8'd0, 1'b0, rec_num);
                if (full)
                    full_lists++;
                rec_num = 4'd0;
                full    = 1'b0;
                start_record();
            end
            else if (full)
            begin
                // bytes past the record limit are dropped
            end
            else if (b == REC_SEP)
            begin
                push_result(KIND_RECORD, rec_num, 3'd0, 5'd0, 8'd0, score, 4'd0);
                rec_num++;
                if (rec_num >= MAX_REC)
                    full = 1'b1;
                start_record();
            end
            else if (b == FLD_SEP)
            begin
                started = 1'b1;
                if (fld_num < FIELD_MAX)
                    fld_num++;
                fld_len = 5'd0;
            end
            else
            begin
                started = 1'b1;
                if (fld_num < SCORE_FIELD)
                begin
                    if (fld_len < cap_of(fld_num))
                        push_result(KIND_CHAR, rec_num, fld_num, fld_len, b, 1'b0, 4'd0);
                end
                else if (fld_num == SCORE_FIELD && fld_len == 5'd0)
                    score = (b == SCORE_ONE);
                if (fld_len < LENGTH_MAX)
                    fld_len++;
            end
            if (expected_q.size() > queued)
            begin
                tail = expected_q[expected_q.size() - 1];
                tail.last = 1'b1;
                expected_q[expected_q.size() - 1] = tail;
            end
        endfunction

        function string describe(input result_t r);
            return $sformatf(
                "kind=%0d rec=%0d fld=%0d pos=%0d byte=%02h flag=%0d count=%0d last=%0d",
                r.kind, r.record_index, r.field_index, r.char_position,
                r.out_byte, r.with_scores, r.record_count, r.last);
        endfunction

        function void check_result(input result_t got);
            result_t want;
            string   bad;
            results_checked++;
            case (got.kind)
                KIND_CHAR:   chars_done++;
                KIND_RECORD: records_done++;
                default:     lists_done++;
            endcase
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d: %s", results_checked, describe(got));
            end
            else
            begin
                want = expected_q.pop_front();
                bad  = "";
                if (got.kind !== want.kind)                   bad = {bad, " kind"};
                if (got.record_index !== want.record_index)   bad = {bad, " record_index"};
                if (got.field_index !== want.field_index)     bad = {bad, " field_index"};
                if (got.char_position !== want.char_position) bad = {bad, " char_position"};
                if (got.out_byte !== want.out_byte)           bad = {bad, " out_byte"};
                if (got.with_scores !== want.with_scores)     bad = {bad, " with_scores"};
                if (got.record_count !== want.record_count)   bad = {bad, " record_count"};
                if (got.last !== want.last)                   bad = {bad, " last"};
                if (bad != "")
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch on result %0d (%s)", results_checked, bad);
                        $display("  expected %s", describe(want));
                        $display("  actual   %s", describe(got));
                    end
                end
            end
        endfunction

        function void close_out();
            if (expected_q.size() != 0)
            begin
                mismatches += expected_q.size();
                $display("%0d expected results never arrived", expected_q.size());
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    int                 src_idle_pct;
    int                 snk_idle_pct;
    int                 counted_items;
    int                 total_bytes;
    result_t            seen;
    splitter_scoreboard sb;

    drfs_in_if  in_ch();
    drfs_out_if out_ch();

    delimited_record_field_splitter #(.MAX_RECORDS(MAX_REC)) dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d results outstanding", sb.expected_q.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                seen.kind          = out_ch.kind;
                seen.record_index  = out_ch.record_index;
                seen.field_index   = out_ch.field_index;
                seen.char_position = out_ch.char_position;
                seen.out_byte      = out_ch.out_byte;
                seen.with_scores   = out_ch.with_scores;
                seen.record_count  = out_ch.record_count;
                seen.last          = out_ch.last;
                sb.check_result(seen);
            end
            if (in_ch.valid && in_ch.ready)
            begin
                sb.note_byte(in_ch.in_byte, in_ch.string_end);
                total_bytes++;
            end
        end
    end

    task automatic send_item(input logic [7:0] b, input logic at_end);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.in_byte    <= b;
        in_ch.string_end <= at_end;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // hold the input off until every predicted result has been checked
    task automatic pause_until_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    // bytes of records past the limit are only dropped, so they are not counted
    task automatic send_text(input logic [7:0] b, input int closed);
        send_item(b, 1'b0);
        if (closed < MAX_REC)
            counted_items++;
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0:       b = 8'h00;
            1:       b = 8'hff;
            2:       b = SCORE_ONE;
            default: b = 8'($urandom_range(0, 255));
        endcase
        if (b == REC_SEP || b == FLD_SEP)
            b = 8'h20;
        return b;
    endfunction

    task automatic send_list(input bit force_full);
        int         n_rec;
        int         n_fld;
        int         n_len;
        int         closed;
        logic [7:0] b;
        closed = 0;
        if (force_full)
            n_rec = $urandom_range(12, 14);
        else
        begin
            case ($urandom_range(0, 9))
                0:       n_rec = $urandom_range(12, 14);
                1, 2:    n_rec = $urandom_range(5, 11);
                default: n_rec = $urandom_range(0, 4);
            endcase
        end
        for (int r = 0; r < n_rec; r++)
        begin
            n_fld = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 7;
            for (int f = 0; f < n_fld; f++)
            begin
                if (f > 0)
                    send_text(FLD_SEP, closed);
                n_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 35)
                                                    : $urandom_range(0, 6);
                for (int i = 0; i < n_len; i++)
                begin
                    b = text_byte();
                    if (f == 6 && i == 0 && $urandom_range(0, 1))
                        b = SCORE_ONE;
                    send_text(b, closed);
                end
            end
            // the last record is left open half the time so the end marker closes it
            if (r < n_rec - 1 || $urandom_range(0, 1))
            begin
                send_text(REC_SEP, closed);
                closed++;
            end
        end
        send_item(8'($urandom_range(0, 255)), 1'b1);
        counted_items++;
    endtask

    task automatic send_noise();
        int         n;
        logic [7:0] b;
        n = $urandom_range(0, 40);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0:       b = REC_SEP;
                1, 2:    b = FLD_SEP;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_item(b, 1'b0);
            counted_items++;
        end
        send_item(8'($urandom_range(0, 255)), 1'b1);
        counted_items++;
    endtask

    task automatic run_phase(input int src_pct, input int snk_pct);
        int goal;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        goal = counted_items + ITEMS_PER_PHASE;
        send_list(1'b1);
        while (counted_items < goal)
        begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                send_list(1'b0);
        end
    endtask

    initial
    begin
        sb = new();
        src_idle_pct = 38;
        snk_idle_pct = 85;
        counted_items = 0;
        total_bytes = 0;
        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.in_byte    <= 8'h00;
        in_ch.string_end <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // end marker on an empty list
        send_item(8'hff, 1'b1);
        // field 0 overrun, zero and all-ones bytes in field 1, score flag set
        send_item("a", 1'b0);
        send_item("b", 1'b0);
        send_item("c", 1'b0);
        send_item("d", 1'b0);
        send_item(FLD_SEP, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b0);
        repeat (5) send_item(FLD_SEP, 1'b0);
        send_item(SCORE_ONE, 1'b0);
        send_item(REC_SEP, 1'b0);
        // empty score field, then the end marker closes the open record
        repeat (6) send_item(FLD_SEP, 1'b0);
        send_item(REC_SEP, 1'b1);
        pause_until_drained();

        run_phase(38, 85);
        pause_until_drained();
        run_phase(85, 38);
        pause_until_drained();
        run_phase(0, 0);
        pause_until_drained();
        repeat (10) @(posedge clk);
        sb.close_out();

        $display("covered %0d bytes in %0d lists: %0d records and %0d characters reported",
                 total_bytes, sb.lists_done, sb.records_done, sb.chars_done);
        $display("%0d lists reached the record limit, %0d mismatches",
                 sb.full_lists, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
src/drfs_pkg.sv
src/drfs_in_if.sv
src/drfs_out_if.sv
src/drfs_parser.sv
src/drfs_out_fifo.sv
src/delimited_record_field_splitter.sv
test/tb.sv
